[design/wfd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
package wfd_pkg;

  localparam int unsigned LEN_BITS   = 64;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;
  localparam logic [3:0] OP_CLOSE   = 4'h8;

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN16  = 3'd1,
    PH_LEN64  = 3'd2,
    PH_MASK   = 3'd3,
    PH_BODY   = 3'd4
  } phase_e;

  // One result as handed from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       has_byte;
    logic       frame_end;
    logic       fin;
    logic [3:0] opcode;
  } entry_t;

endpackage

[design/wfd_front.sv]
// Header parser: tracks the frame phase and emits one queue entry per result.
module wfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output wfd_pkg::entry_t   q_entry_o
);

  wfd_pkg::phase_e                phase_q, phase_d;
  logic [2:0]                     cnt_q, cnt_d;
  logic                           fin_q, fin_d;
  logic [3:0]                     op_q, op_d;
  logic                           mask_q, mask_d;
  logic [31:0]                    key_q, key_d;
  logic [1:0]                     pos_q, pos_d;
  logic [wfd_pkg::LEN_BITS-1:0]   len_q, len_d;

  logic                           accept;
  logic                           sat;
  logic [wfd_pkg::LEN_BITS-1:0]   len_shift;
  logic [wfd_pkg::LEN_BITS-1:0]   len_body;
  logic [wfd_pkg::LEN_BITS-1:0]   hdr_len;
  logic [2:0]                     cnt_inc;
  logic                           len_done;
  logic [7:0]                     key_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Saturate once the next shift would push bits out of the length register.
  assign sat       = |len_q[wfd_pkg::LEN_BITS-1 -: 8];
  assign len_shift = sat ? wfd_pkg::LEN_MAX : {len_q[wfd_pkg::LEN_BITS-9:0], in_byte_i};
  assign len_body  = (len_q != '0) ? len_q - 1'b1 : '0;
  assign hdr_len   = {{(wfd_pkg::LEN_BITS-7){1'b0}}, in_byte_i[6:0]};
  assign cnt_inc   = cnt_q + 3'd1;
  assign len_done  = ((phase_q == wfd_pkg::PH_LEN16) && (cnt_inc == 3'd2)) ||
                     ((phase_q == wfd_pkg::PH_LEN64) && (cnt_inc == 3'd0));

  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    op_d    = op_q;
    mask_d  = mask_q;
    key_d   = key_q;
    pos_d   = pos_q;
    len_d   = len_q;
    if (accept) begin
      case (phase_q)
        wfd_pkg::PH_LEN16, wfd_pkg::PH_LEN64: begin
          len_d = len_shift;
          cnt_d = cnt_inc;
          if (len_done) begin
            cnt_d = 3'd0;
            if (mask_q) begin
              phase_d = wfd_pkg::PH_MASK;
            end else begin
              pos_d   = 2'd0;
              phase_d = (len_shift == '0) ? wfd_pkg::PH_HEADER : wfd_pkg::PH_BODY;
            end
          end
        end
        wfd_pkg::PH_MASK: begin
          key_d = {key_q[23:0], in_byte_i};
          cnt_d = cnt_inc;
          if (cnt_inc == 3'd4) begin
            cnt_d   = 3'd0;
            pos_d   = 2'd0;
            phase_d = (len_q == '0) ? wfd_pkg::PH_HEADER : wfd_pkg::PH_BODY;
          end
        end
        wfd_pkg::PH_BODY: begin
          len_d = len_body;
          if (mask_q) begin
            pos_d = pos_q + 2'd1;
          end
          if (len_body == '0) begin
            phase_d = wfd_pkg::PH_HEADER;
            cnt_d   = 3'd0;
            pos_d   = 2'd0;
          end
        end
        default: begin
          phase_d = wfd_pkg::PH_HEADER;
          if (cnt_q == 3'd0) begin
            fin_d = in_byte_i[7];
            op_d  = in_byte_i[3:0];
            cnt_d = 3'd1;
          end else begin
            mask_d = in_byte_i[7];
            cnt_d  = 3'd0;
            if (in_byte_i[6:0] == wfd_pkg::LEN_CODE16) begin
              len_d   = '0;
              phase_d = wfd_pkg::PH_LEN16;
            end else if (in_byte_i[6:0] == wfd_pkg::LEN_CODE64) begin
              len_d   = '0;
              phase_d = wfd_pkg::PH_LEN64;
            end else begin
              len_d = hdr_len;
              if (in_byte_i[7]) begin
                phase_d = wfd_pkg::PH_MASK;
              end else begin
                pos_d   = 2'd0;
                phase_d = (hdr_len == '0) ? wfd_pkg::PH_HEADER : wfd_pkg::PH_BODY;
              end
            end
          end
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    q_push_o            = 1'b0;
    q_entry_o.data      = 8'd0;
    q_entry_o.key       = 8'd0;
    q_entry_o.has_byte  = 1'b0;
    q_entry_o.frame_end = 1'b1;
    q_entry_o.fin       = fin_q;
    q_entry_o.opcode    = op_q;
    case (phase_q)
      wfd_pkg::PH_LEN16, wfd_pkg::PH_LEN64: begin
        q_push_o = accept && len_done && !mask_q && (len_shift == '0);
      end
      wfd_pkg::PH_MASK: begin
        q_push_o = accept && (cnt_inc == 3'd4) && (len_q == '0);
      end
      wfd_pkg::PH_BODY: begin
        q_push_o            = accept;
        q_entry_o.data      = in_byte_i;
        q_entry_o.key       = mask_q ? key_byte : 8'd0;
        q_entry_o.has_byte  = 1'b1;
        q_entry_o.frame_end = (len_body == '0);
      end
      default: begin
        // Unmasked short header with zero length closes an empty frame here.
        q_push_o = accept && (cnt_q != 3'd0) && !in_byte_i[7] &&
                   (in_byte_i[6:0] == 7'd0);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wfd_pkg::PH_HEADER;
      cnt_q   <= 3'd0;
      fin_q   <= 1'b0;
      op_q    <= 4'd0;
      mask_q  <= 1'b0;
      key_q   <= 32'd0;
      pos_q   <= 2'd0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      key_q   <= key_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

endmodule

[design/wfd_queue.sv]
// Short result queue between the parser and the output stage.
module wfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wfd_pkg::entry_t entry_i,
  input  logic            pop_i,
  output wfd_pkg::entry_t entry_o,
  output logic            full_o,
  output logic            empty_o
);

  wfd_pkg::entry_t                mem_q [wfd_pkg::Q_DEPTH];
  logic [wfd_pkg::Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [wfd_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == wfd_pkg::Q_CNT_W'(wfd_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

[design/wfd_back.sv]
// Output stage: unmasks the payload byte and holds the result beat.
module wfd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_empty_i,
  input  wfd_pkg::entry_t                  q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wfd_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                             out_user_o,
  output logic                             out_last_o
);

  logic        vld_q;
  logic [7:0]  byte_q;
  logic        has_q;
  logic        end_q;
  logic        fin_q;
  logic [3:0]  op_q;
  logic        close_q;

  // Refill whenever the held beat is empty or leaves this cycle.
  assign q_pop_o = !q_empty_i && (!vld_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (!vld_q || out_ready_i) begin
      vld_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q  <= q_entry_i.data ^ q_entry_i.key;
      has_q   <= q_entry_i.has_byte;
      end_q   <= q_entry_i.frame_end;
      fin_q   <= q_entry_i.fin;
      op_q    <= q_entry_i.opcode;
      close_q <= (q_entry_i.opcode == wfd_pkg::OP_CLOSE);
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = {2'b00, close_q, op_q, fin_q, byte_q};
  assign out_user_o  = has_q;
  assign out_last_o  = end_q;

endmodule

[design/websocket_frame_deframer_unit.sv]
// A body byte accepted by the parser is written into the queue, then registered in the output stage as a result beat.
// Throughput: one byte per cycle; the parser stalls only when the four-entry queue is full.
// Header, extended length and mask key bytes give no beat except to close an empty frame.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase and empties
// the queue and the output register; the input accepts bytes while the queue is not full.
module websocket_frame_deframer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,  // [7:0] rx_byte
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] out_byte, [8] fin_flag, [12:9] frame_opcode, [13] close_frame, [15:14] zero
  output logic [wfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tuser_o,  // [0] has_byte
  output logic                             m_axis_tlast_o   // frame_end
);

  logic            q_push, q_pop, q_full, q_empty;
  wfd_pkg::entry_t push_entry, pop_entry;

  wfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  wfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  wfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

[design/wfd_checker.sv]
// Port-level checks for the deframer, bound to the top level.
module wfd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [wfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input logic                             m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result beat valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o[7:0] == 8'd0))
    else $error("beat without payload is not a zero-byte frame end");

  a_close_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[13] == (m_axis_tdata_o[12:9] == wfd_pkg::OP_CLOSE)))
    else $error("close flag disagrees with opcode");

endmodule

bind websocket_frame_deframer_unit wfd_checker u_wfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/sv/tb_websocket_frame_deframer_unit.sv]
// Testbench for the WebSocket frame deframer: byte-stream frames in, checked payload beats out.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;

  // One payload beat as seen on the master side.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fend;
    logic       fin;
    logic [3:0] opc;
    logic       close_b;
    logic [1:0] pad;
  } beat_t;

  class deframe_scoreboard;
    wfd_pkg::phase_e              ph;
    logic [2:0]                   cnt;
    logic                         fin_r;
    logic [3:0]                   opc_r;
    logic                         mask_r;
    logic [31:0]                  key_r;
    logic [1:0]                   pos_r;
    logic [wfd_pkg::LEN_BITS-1:0] rem_r;
    beat_t                        want_q[$];
    int                           errors;

    function new();
      ph     = wfd_pkg::PH_HEADER;
      cnt    = '0;
      fin_r  = 1'b0;
      opc_r  = '0;
      mask_r = 1'b0;
      key_r  = '0;
      pos_r  = '0;
      rem_r  = '0;
      errors = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void add_beat(logic [7:0] d, logic has, logic fend);
      beat_t w;
      w = '{data: d, has: has, fend: fend, fin: fin_r, opc: opc_r,
            close_b: (opc_r == wfd_pkg::OP_CLOSE), pad: 2'b00};
      want_q.push_back(w);
    endfunction

    function void to_header();
      ph    = wfd_pkg::PH_HEADER;
      cnt   = '0;
      pos_r = '0;
    endfunction

    // Length known: go to the mask key, the body, or close an empty frame.
    function void length_done();
      cnt = '0;
      if (mask_r) begin
        ph = wfd_pkg::PH_MASK;
      end else if (rem_r == 0) begin
        add_beat(8'h00, 1'b0, 1'b1);
        to_header();
      end else begin
        ph    = wfd_pkg::PH_BODY;
        pos_r = '0;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] d;
      case (ph)
        wfd_pkg::PH_LEN16, wfd_pkg::PH_LEN64: begin
          if (rem_r > (wfd_pkg::LEN_MAX >> 8)) rem_r = wfd_pkg::LEN_MAX;
          else rem_r = {rem_r[wfd_pkg::LEN_BITS-9:0], b};
          cnt = cnt + 3'd1;
          if ((ph == wfd_pkg::PH_LEN16 && cnt == 3'd2) ||
              (ph == wfd_pkg::PH_LEN64 && cnt == 3'd0)) length_done();
        end
        wfd_pkg::PH_MASK: begin
          key_r = {key_r[23:0], b};
          cnt   = cnt + 3'd1;
          if (cnt == 3'd4) begin
            cnt   = '0;
            pos_r = '0;
            if (rem_r == 0) begin
              add_beat(8'h00, 1'b0, 1'b1);
              to_header();
            end else begin
              ph = wfd_pkg::PH_BODY;
            end
          end
        end
        wfd_pkg::PH_BODY: begin
          d = b;
          if (mask_r) begin
            d     = b ^ key_r[8*(3-pos_r) +: 8];
            pos_r = pos_r + 2'd1;
          end
          if (rem_r != 0) rem_r = rem_r - 1;
          if (rem_r == 0) begin
            add_beat(d, 1'b1, 1'b1);
            to_header();
          end else begin
            add_beat(d, 1'b1, 1'b0);
          end
        end
        default: begin
          ph = wfd_pkg::PH_HEADER;
          if (cnt == 3'd0) begin
            fin_r = b[7];
            opc_r = b[3:0];
            cnt   = 3'd1;
          end else begin
            mask_r = b[7];
            cnt    = '0;
            rem_r  = '0;
            if (b[6:0] == wfd_pkg::LEN_CODE16) begin
              ph = wfd_pkg::PH_LEN16;
            end else if (b[6:0] == wfd_pkg::LEN_CODE64) begin
              ph = wfd_pkg::PH_LEN64;
            end else begin
              rem_r = {{(wfd_pkg::LEN_BITS-7){1'b0}}, b[6:0]};
              length_done();
            end
          end
        end
      endcase
    endfunction

    function void check_beat(logic [wfd_pkg::OUT_DATA_W-1:0] tdata, logic tuser, logic tlast);
      beat_t got;
      beat_t w;
      got = '{data: tdata[7:0], has: tuser, fend: tlast, fin: tdata[8],
              opc: tdata[12:9], close_b: tdata[13], pad: tdata[15:14]};
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: tdata %h tuser %b tlast %b", tdata, tuser, tlast);
        return;
      end
      w = want_q.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10)
          $display({"beat mismatch: exp byte %h has %b end %b fin %b op %h close %b pad %b",
                    " / got byte %h has %b end %b fin %b op %h close %b pad %b"},
                   w.data, w.has, w.fend, w.fin, w.opc, w.close_b, w.pad,
                   got.data, got.has, got.fend, got.fin, got.opc, got.close_b, got.pad);
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           s_axis_tvalid_i;
  logic                           s_axis_tready_o;
  logic [7:0]                     s_axis_tdata_i;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i;
  logic [wfd_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                           m_axis_tuser_o;
  logic                           m_axis_tlast_o;

  deframe_scoreboard sb;
  bit                calm = 1'b0;
  int                n_sent = 0;

  websocket_frame_deframer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stall the result side at random, except during the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready_i = calm || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_beat(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
  end

  // Offer one byte at the falling edge and hold it until the deframer accepts it.
  task automatic push(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_byte(b);
    n_sent++;
    @(negedge clk_i);
  endtask

  // len_kind: 0 short 7-bit length, 1 16-bit extended, 2 64-bit extended.
  task automatic send_frame(input logic [7:0] hdr0, input logic mask_b, input int len_kind,
                            input logic [63:0] len, input int body_n);
    logic [31:0] key;
    key = $urandom;
    push(hdr0);
    case (len_kind)
      0: push({mask_b, len[6:0]});
      1: begin
        push({mask_b, wfd_pkg::LEN_CODE16});
        push(len[15:8]);
        push(len[7:0]);
      end
      default: begin
        push({mask_b, wfd_pkg::LEN_CODE64});
        for (int i = 7; i >= 0; i--) push(len[8*i +: 8]);
      end
    endcase
    if (mask_b) for (int i = 3; i >= 0; i--) push(key[8*i +: 8]);
    for (int i = 0; i < body_n; i++) push(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int          r;
    int          frames;
    int          kind;
    logic [63:0] len;
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty close frame, unmasked.
    push(8'h88); push(8'h00);
    // RSV bits set, opcode 15, FIN clear; masked single byte.
    push(8'h7F); push(8'h81);
    push(8'hA5); push(8'h5A); push(8'hFF); push(8'h00);
    push(8'hFF);
    // Masked 16-bit length of zero: empty frame closed on the last key byte.
    push(8'h82); push(8'hFE); push(8'h00); push(8'h00);
    push(8'h12); push(8'h34); push(8'h56); push(8'h78);
    // Unmasked two-byte body with extreme data.
    push(8'h00); push(8'h02); push(8'h00); push(8'hFF);

    frames = 0;
    while (n_sent < 720) begin
      calm = (frames >= 20 && frames < 40);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        kind = 0;
        len  = (r < 55) ? 64'($urandom_range(0, 12)) : 64'($urandom_range(0, 125));
      end else if (r < 88) begin
        kind = 1;
        len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300)) :
                                             64'($urandom_range(0, 20));
      end else begin
        kind = 2;
        len  = 64'($urandom_range(0, 24));
      end
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), kind, len, int'(len));
      frames++;
    end
    calm = 1'b0;
    // Huge 64-bit length with the reserved top bit set; leave the frame open.
    send_frame(8'h02, 1'b1, 2, 64'h8000_0000_0000_0010, 8);
    s_axis_tvalid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_websocket_frame_deframer_unit: clean");
    else
      $display("tb_websocket_frame_deframer_unit: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_websocket_frame_deframer_unit: errors");
    $finish;
  end

endmodule
